@@ sv/dtq_pkg.sv @@
// dtq_pkg: sizes, codes and the control/status bundles of the delta timer queue
// used by dtq_ctrl, dtq_datapath and delta_timer_queue; no dependencies
package dtq_pkg;

  // queue geometry and field widths
  localparam int QueueDepth = 16;
  localparam int IdBits     = 8;
  localparam int TickBits   = 16;
  localparam int MaxResults = 16;
  localparam int OpBits     = 2;
  localparam int StatusBits = 3;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);

  typedef enum logic [OpBits-1:0] {
    OP_INSERT = 2'd0,
    OP_TICK   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [StatusBits-1:0] {
    STS_DONE      = 3'd0,
    STS_RELEASED  = 3'd1,
    STS_FULL      = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_ZERO_WAIT = 3'd4
  } status_e;

  // source of the id field of an output word
  typedef enum logic [1:0] {
    IDS_TID,
    IDS_HEAD,
    IDS_ZERO
  } id_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_WALK,
    S_REM_WALK,
    S_REM_FIX,
    S_TICK_REL
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    pos_clr;
    logic    pos_inc;
    logic    rem_sub;
    logic    do_insert;
    logic    do_remove;
    logic    do_fix;
    logic    do_dec;
    logic    do_release;
    logic    do_clear;
    logic    emit;
    status_e emit_status;
    id_sel_e emit_id;
    logic    emit_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_e op;
    logic    wait_zero;
    logic    full;
    logic    empty;
    logic    ins_more;
    logic    pos_end;
    logic    id_match;
    logic    rel_ok;
    logic    rel_last;
    logic    emit_ok;
  } sts_t;

endpackage

@@ sv/dtq_datapath.sv @@
// dtq_datapath: entry registers, walk pointer, remainder and output word register
// depends on dtq_pkg; driven by commands from dtq_ctrl
module dtq_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [dtq_pkg::OpBits-1:0]     opcode_i,
  input  logic [dtq_pkg::IdBits-1:0]     thread_id_i,
  input  logic [dtq_pkg::TickBits-1:0]   wait_ticks_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [dtq_pkg::StatusBits-1:0] status_o,
  output logic [dtq_pkg::IdBits-1:0]     released_id_o,
  output logic                           last_o,
  input  dtq_pkg::cmd_t                  cmd_i,
  output dtq_pkg::sts_t                  sts_o
);
  import dtq_pkg::*;

  logic [TickBits-1:0] delta_q [QueueDepth];
  logic [TickBits-1:0] delta_d [QueueDepth];
  logic [IdBits-1:0]   ids_q   [QueueDepth];
  logic [IdBits-1:0]   ids_d   [QueueDepth];
  logic [TickBits-1:0] delta_prev [QueueDepth];
  logic [TickBits-1:0] delta_next [QueueDepth];
  logic [IdBits-1:0]   ids_prev   [QueueDepth];
  logic [IdBits-1:0]   ids_next   [QueueDepth];

  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       pos_q, pos_d;
  logic [TickBits-1:0]   rem_q, rem_d;
  opcode_e               op_q;
  logic [IdBits-1:0]     tid_q;

  logic                  out_valid_q, out_valid_d;
  logic [StatusBits-1:0] status_q;
  logic [IdBits-1:0]     out_id_q;
  logic                  last_q;

  logic [IdxW-1:0]     pos_idx;
  logic [TickBits-1:0] rd_delta;
  logic [IdBits-1:0]   rd_id;
  logic [TickBits-1:0] succ_delta;
  logic [TickBits:0]   fix_sum;
  logic [TickBits-1:0] fix_val;
  logic [CntW-1:0]     drop_pos;
  logic                emit_ok;

  // single read port at the walk pointer
  assign pos_idx    = pos_q[IdxW-1:0];
  assign rd_delta   = delta_q[pos_idx];
  assign rd_id      = ids_q[pos_idx];
  assign succ_delta = rd_delta - rem_q;
  assign fix_sum    = {1'b0, rd_delta} + {1'b0, rem_q};
  assign fix_val    = fix_sum[TickBits] ? {TickBits{1'b1}} : fix_sum[TickBits-1:0];
  assign drop_pos   = cmd_i.do_release ? '0 : pos_q;
  assign emit_ok    = !out_valid_q || out_ready_i;

  // neighbor views for shifting up and down
  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      if (i == 0) begin
        delta_prev[i] = delta_q[i];
        ids_prev[i]   = ids_q[i];
      end else begin
        delta_prev[i] = delta_q[i-1];
        ids_prev[i]   = ids_q[i-1];
      end
      if (i == QueueDepth - 1) begin
        delta_next[i] = delta_q[i];
        ids_next[i]   = ids_q[i];
      end else begin
        delta_next[i] = delta_q[i+1];
        ids_next[i]   = ids_q[i+1];
      end
    end
  end

  // entry update: insert, drop, head decrement, merge after remove
  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      delta_d[i] = delta_q[i];
      ids_d[i]   = ids_q[i];
      if (cmd_i.do_insert) begin
        if (CntW'(i) == pos_q) begin
          delta_d[i] = rem_q;
          ids_d[i]   = tid_q;
        end else if (CntW'(i) > pos_q) begin
          delta_d[i] = (CntW'(i) == pos_q + 1'b1) ? succ_delta : delta_prev[i];
          ids_d[i]   = ids_prev[i];
        end
      end
      if (cmd_i.do_remove || cmd_i.do_release) begin
        if (CntW'(i) >= drop_pos) begin
          delta_d[i] = delta_next[i];
          ids_d[i]   = ids_next[i];
        end
      end
    end
    if (cmd_i.do_dec && (delta_q[0] != '0)) begin
      delta_d[0] = delta_q[0] - 1'b1;
    end
    if (cmd_i.do_fix && (pos_q < count_q)) begin
      delta_d[pos_idx] = fix_val;
    end
  end

  // entries carry no reset, only entries below the count are read
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QueueDepth; i++) begin
      delta_q[i] <= delta_d[i];
      ids_q[i]   <= ids_d[i];
    end
  end

  // count, walk pointer and remainder
  always_comb begin
    count_d = count_q;
    if (cmd_i.do_insert) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.do_remove || cmd_i.do_release) begin
      count_d = count_q - 1'b1;
    end else if (cmd_i.do_clear) begin
      count_d = '0;
    end
    pos_d = pos_q;
    if (cmd_i.pos_clr) begin
      pos_d = '0;
    end else if (cmd_i.pos_inc || cmd_i.do_release) begin
      pos_d = pos_q + 1'b1;
    end
    rem_d = rem_q;
    if (cmd_i.load_in) begin
      rem_d = wait_ticks_i;
    end else if (cmd_i.rem_sub) begin
      rem_d = rem_q - rd_delta;
    end else if (cmd_i.do_remove) begin
      rem_d = rd_delta;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  // captured input word
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (cmd_i.load_in) begin
      op_q  <= opcode_e'(opcode_i);
      tid_q <= thread_id_i;
    end
  end

  // output word register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.emit_status;
      last_q   <= cmd_i.emit_last;
      case (cmd_i.emit_id)
        IDS_TID:  out_id_q <= tid_q;
        IDS_HEAD: out_id_q <= ids_q[0];
        IDS_ZERO: out_id_q <= '0;
        default:  out_id_q <= '0;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign released_id_o = out_id_q;
  assign last_o        = last_q;

  // status toward the controller
  always_comb begin
    sts_o.op        = op_q;
    sts_o.wait_zero = (rem_q == '0);
    sts_o.full      = (count_q == CntW'(QueueDepth));
    sts_o.empty     = (count_q == '0);
    sts_o.ins_more  = (pos_q < count_q) && (rd_delta <= rem_q);
    sts_o.pos_end   = (pos_q >= count_q);
    sts_o.id_match  = (rd_id == tid_q);
    sts_o.rel_ok    = (count_q != '0) && (delta_q[0] == '0)
                      && (32'(pos_q) < 32'(MaxResults));
    sts_o.rel_last  = !((count_q > CntW'(1)) && (delta_q[1] == '0)
                      && (32'(pos_q) + 32'd1 < 32'(MaxResults)));
    sts_o.emit_ok   = emit_ok;
  end

endmodule

@@ sv/dtq_ctrl.sv @@
// dtq_ctrl: sequencer for insert, tick, remove and clear of the delta timer queue
// depends on dtq_pkg; commands dtq_datapath
module dtq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dtq_pkg::sts_t sts_i,
  output dtq_pkg::cmd_t cmd_o
);
  import dtq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts_i.op)
          OP_INSERT: begin
            if (sts_i.wait_zero || sts_i.full) begin
              if (sts_i.emit_ok) state_d = S_IDLE;
            end else begin
              state_d = S_INS_WALK;
            end
          end
          OP_TICK: begin
            if (sts_i.empty) begin
              if (sts_i.emit_ok) state_d = S_IDLE;
            end else begin
              state_d = S_TICK_REL;
            end
          end
          OP_REMOVE: state_d = S_REM_WALK;
          OP_CLEAR: begin
            if (sts_i.emit_ok) state_d = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_INS_WALK: begin
        if (!sts_i.ins_more && sts_i.emit_ok) state_d = S_IDLE;
      end
      S_REM_WALK: begin
        if (sts_i.pos_end) begin
          if (sts_i.emit_ok) state_d = S_IDLE;
        end else if (sts_i.id_match) begin
          state_d = S_REM_FIX;
        end
      end
      S_REM_FIX: begin
        if (sts_i.emit_ok) state_d = S_IDLE;
      end
      S_TICK_REL: begin
        if (sts_i.emit_ok && (!sts_i.rel_ok || sts_i.rel_last)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o             = '0;
    cmd_o.emit_status = STS_DONE;
    cmd_o.emit_id     = IDS_TID;
    cmd_o.emit_last   = 1'b1;
    in_ready_o        = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_DISPATCH: begin
        cmd_o.pos_clr = 1'b1;
        case (sts_i.op)
          OP_INSERT: begin
            if (sts_i.wait_zero) begin
              cmd_o.emit        = sts_i.emit_ok;
              cmd_o.emit_status = STS_ZERO_WAIT;
            end else if (sts_i.full) begin
              cmd_o.emit        = sts_i.emit_ok;
              cmd_o.emit_status = STS_FULL;
            end
          end
          OP_TICK: begin
            if (sts_i.empty) begin
              cmd_o.emit    = sts_i.emit_ok;
              cmd_o.emit_id = IDS_ZERO;
            end else begin
              cmd_o.do_dec = 1'b1;
            end
          end
          OP_REMOVE: begin
          end
          OP_CLEAR: begin
            cmd_o.emit     = sts_i.emit_ok;
            cmd_o.emit_id  = IDS_ZERO;
            cmd_o.do_clear = sts_i.emit_ok;
          end
          default: begin
          end
        endcase
      end
      S_INS_WALK: begin
        if (sts_i.ins_more) begin
          cmd_o.pos_inc = 1'b1;
          cmd_o.rem_sub = 1'b1;
        end else begin
          cmd_o.emit      = sts_i.emit_ok;
          cmd_o.do_insert = sts_i.emit_ok;
        end
      end
      S_REM_WALK: begin
        if (sts_i.pos_end) begin
          cmd_o.emit        = sts_i.emit_ok;
          cmd_o.emit_status = STS_NOT_FOUND;
        end else if (sts_i.id_match) begin
          cmd_o.do_remove = 1'b1;
        end else begin
          cmd_o.pos_inc = 1'b1;
        end
      end
      S_REM_FIX: begin
        cmd_o.emit   = sts_i.emit_ok;
        cmd_o.do_fix = sts_i.emit_ok;
      end
      S_TICK_REL: begin
        if (sts_i.rel_ok) begin
          cmd_o.emit        = sts_i.emit_ok;
          cmd_o.do_release  = sts_i.emit_ok;
          cmd_o.emit_status = STS_RELEASED;
          cmd_o.emit_id     = IDS_HEAD;
          cmd_o.emit_last   = sts_i.rel_last;
        end else begin
          cmd_o.emit    = sts_i.emit_ok;
          cmd_o.emit_id = IDS_ZERO;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/delta_timer_queue.sv @@
// Delta timer queue: up to 16 waiters sorted by expiry, each stored as a delta from its
// predecessor. One word is taken at a time; input ready is high only between words.
// An insert walks one entry per cycle to its slot; a refused insert (zero wait or full
// queue) skips the walk. Remove walks likewise until the id matches, then merges the
// removed delta into the successor; a remove that finds nothing walks all entries. A tick
// decrements the head, then releases expired threads one per output word (at most 16);
// a tick on an empty queue and a clear answer with a single word. The walk goes through
// the single read port of the entry array; a stalled output word holds each step that
// emits.
// depends on dtq_pkg, dtq_ctrl and dtq_datapath
module delta_timer_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [dtq_pkg::OpBits-1:0]     opcode_i,
  input  logic [dtq_pkg::IdBits-1:0]     thread_id_i,
  input  logic [dtq_pkg::TickBits-1:0]   wait_ticks_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dtq_pkg::StatusBits-1:0] status_o,
  output logic [dtq_pkg::IdBits-1:0]     released_id_o,
  output logic                           last_o
);
  import dtq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  dtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // entry store and output word
  dtq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (opcode_i),
    .thread_id_i   (thread_id_i),
    .wait_ticks_i  (wait_ticks_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .released_id_o (released_id_o),
    .last_o        (last_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

@@ bench/delta_timer_queue_test.sv @@
// delta_timer_queue_test: self-checking bench for the delta timer queue, directed and random
// words with random idling on both sides, checked against an in-bench queue predictor
// depends on dtq_pkg and delta_timer_queue
module delta_timer_queue_test;
  import dtq_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int RandomReqs = 86;
  localparam int MaxPrinted = 40;

  // one input word as the driver holds it
  typedef struct {
    opcode_e             op;
    logic [IdBits-1:0]   tid;
    logic [TickBits-1:0] ticks;
  } timer_req_t;

  // one result word the queue should produce
  typedef struct {
    status_e           status;
    logic [IdBits-1:0] id;
    logic              last;
  } timer_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid     = 1'b0;
  logic                  in_ready_o;
  logic [OpBits-1:0]     opcode_i     = '0;
  logic [IdBits-1:0]     thread_id_i  = '0;
  logic [TickBits-1:0]   wait_ticks_i = '0;
  logic                  out_valid_o;
  logic                  out_ready    = 1'b0;
  logic [StatusBits-1:0] status_o;
  logic [IdBits-1:0]     released_id_o;
  logic                  last_o;

  // requests still to send and result words still owed
  timer_req_t  req_fifo[$];
  timer_word_t awaited_words[$];

  // shadow of the queue contents
  logic [TickBits-1:0] shadow_delta[QueueDepth];
  logic [IdBits-1:0]   shadow_id[QueueDepth];
  int                  shadow_count = 0;

  int mismatch_n = 0;
  int accepted_n = 0;
  int total_n    = 0;
  int cycle_n    = 0;

  timer_req_t cur_req;
  int         gap_left   = 0;
  int         in_run     = 0;
  int         stall_left = 0;
  int         out_run    = 0;

  delta_timer_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .thread_id_i   (thread_id_i),
    .wait_ticks_i  (wait_ticks_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .status_o      (status_o),
    .released_id_o (released_id_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  task report_mismatch(input string what);
    mismatch_n++;
    if (mismatch_n <= MaxPrinted) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task owe_word(input status_e status, input logic [IdBits-1:0] id, input logic last);
    timer_word_t w;
    w.status = status;
    w.id     = id;
    w.last   = last;
    awaited_words.push_back(w);
  endtask

  // take entry pos out, closing the gap
  task shadow_drop(input int pos);
    int i;
    for (i = pos; i + 1 < shadow_count; i++) begin
      shadow_delta[i] = shadow_delta[i+1];
      shadow_id[i]    = shadow_id[i+1];
    end
    if (shadow_count > 0) shadow_count--;
  endtask

  // apply one accepted request to the shadow queue and owe its result words
  task timer_apply(input timer_req_t req);
    int                  pos;
    int                  i;
    int                  n;
    logic [TickBits-1:0] rem;
    logic [TickBits:0]   sum;
    case (req.op)
      OP_INSERT: begin
        if (req.ticks == '0) begin
          owe_word(STS_ZERO_WAIT, req.tid, 1'b1);
        end else if (shadow_count >= QueueDepth) begin
          owe_word(STS_FULL, req.tid, 1'b1);
        end else begin
          // walk past every entry expiring no later than the new one
          rem = req.ticks;
          pos = 0;
          while (pos < shadow_count && shadow_delta[pos] <= rem) begin
            rem -= shadow_delta[pos];
            pos++;
          end
          for (i = shadow_count; i > pos; i--) begin
            shadow_delta[i] = shadow_delta[i-1];
            shadow_id[i]    = shadow_id[i-1];
          end
          shadow_delta[pos] = rem;
          shadow_id[pos]    = req.tid;
          shadow_count++;
          if (pos + 1 < shadow_count) shadow_delta[pos+1] -= rem;
          owe_word(STS_DONE, req.tid, 1'b1);
        end
      end
      OP_TICK: begin
        n = 0;
        if (shadow_count > 0) begin
          // saturating decrement, then release every expired head
          if (shadow_delta[0] != '0) shadow_delta[0]--;
          while (shadow_count > 0 && shadow_delta[0] == '0 && n < MaxResults) begin
            owe_word(STS_RELEASED, shadow_id[0], 1'b0);
            n++;
            shadow_drop(0);
          end
        end
        if (n == 0) owe_word(STS_DONE, '0, 1'b1);
        else awaited_words[awaited_words.size()-1].last = 1'b1;
      end
      OP_REMOVE: begin
        pos = 0;
        while (pos < shadow_count && shadow_id[pos] != req.tid) pos++;
        if (pos >= shadow_count) begin
          owe_word(STS_NOT_FOUND, req.tid, 1'b1);
        end else begin
          // the successor inherits the removed delta, saturating
          if (pos + 1 < shadow_count) begin
            sum = {1'b0, shadow_delta[pos+1]} + {1'b0, shadow_delta[pos]};
            shadow_delta[pos+1] = sum[TickBits] ? '1 : sum[TickBits-1:0];
          end
          shadow_drop(pos);
          owe_word(STS_DONE, req.tid, 1'b1);
        end
      end
      default: begin
        shadow_count = 0;
        owe_word(STS_DONE, '0, 1'b1);
      end
    endcase
  endtask

  // idle cycles before the next word, with runs of back-to-back words
  function automatic int draw_idle(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      run_left = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // ids mostly from a small pool so removes find their thread
  function automatic logic [IdBits-1:0] pick_tid();
    if ($urandom_range(0, 3) != 0) return IdBits'($urandom_range(0, 11));
    return IdBits'($urandom_range(0, (1 << IdBits) - 1));
  endfunction

  task queue_req(input opcode_e op, input logic [IdBits-1:0] tid,
                 input logic [TickBits-1:0] ticks);
    timer_req_t r;
    r.op    = op;
    r.tid   = tid;
    r.ticks = ticks;
    req_fifo.push_back(r);
  endtask

  // driver: one word at a time, predicted as it is accepted
  always @(posedge clk_i) begin : driver
    logic vld;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      vld = in_valid;
      if (in_valid && in_ready_o) begin
        timer_apply(cur_req);
        accepted_n++;
        vld      = 1'b0;
        gap_left = draw_idle(in_run);
      end
      if (!vld && req_fifo.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          cur_req      = req_fifo.pop_front();
          vld          = 1'b1;
          opcode_i     <= cur_req.op;
          thread_id_i  <= cur_req.tid;
          wait_ticks_i <= cur_req.ticks;
        end
      end
      in_valid <= vld;
    end
  end

  // monitor: compare each accepted result word with the oldest one owed
  always @(posedge clk_i) begin : monitor
    timer_word_t w;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (awaited_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word status %0d id %0d last %0d",
                                    status_o, released_id_o, last_o));
        end else begin
          w = awaited_words.pop_front();
          if (status_o !== w.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_o, w.status));
          if (released_id_o !== w.id)
            report_mismatch($sformatf("released_id %0d, expected %0d", released_id_o, w.id));
          if (last_o !== w.last)
            report_mismatch($sformatf("last %0d, expected %0d", last_o, w.last));
        end
        stall_left = draw_idle(out_run);
      end
      // stall counts down only while a word is waiting
      if (stall_left > 0) begin
        if (out_valid_o) stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin : watchdog
    cycle_n++;
    if (cycle_n >= CycleLimit) begin
      $display("[delta_timer_queue] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int r;
    logic [TickBits-1:0] ticks;

    // empty queue corners
    queue_req(OP_TICK, 8'h3C, 16'h1234);
    queue_req(OP_REMOVE, 8'hFF, '0);
    queue_req(OP_INSERT, 8'h55, '0);
    // fill to full: longest waits, equal expiry, duplicate ids, mixed bits
    queue_req(OP_INSERT, 8'h00, 16'hFFFF);
    queue_req(OP_INSERT, 8'hFF, 16'hFFFF);
    queue_req(OP_INSERT, 8'h12, 16'd1);
    queue_req(OP_INSERT, 8'h34, 16'd1);
    queue_req(OP_INSERT, 8'h12, 16'd2);
    queue_req(OP_INSERT, 8'h80, 16'd40000);
    queue_req(OP_INSERT, 8'h5A, 16'hAAAA);
    queue_req(OP_INSERT, 8'hA5, 16'h5555);
    queue_req(OP_INSERT, 8'h03, 16'd2);
    queue_req(OP_INSERT, 8'h04, 16'd1);
    queue_req(OP_INSERT, 8'h7F, 16'h8000);
    queue_req(OP_INSERT, 8'h40, 16'd7);
    queue_req(OP_INSERT, 8'h20, 16'd7);
    queue_req(OP_INSERT, 8'h10, 16'd3);
    queue_req(OP_INSERT, 8'h08, 16'h00FF);
    queue_req(OP_INSERT, 8'h02, 16'd1);
    queue_req(OP_INSERT, 8'h99, 16'd5);
    // duplicate id removal, a multi-release tick, then clear
    queue_req(OP_REMOVE, 8'h12, '0);
    queue_req(OP_TICK, '0, '0);
    queue_req(OP_CLEAR, 8'hC3, 16'hFFFF);
    queue_req(OP_TICK, '0, '0);

    // random traffic, mostly inserts with short waits and ticks
    repeat (RandomReqs) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        r = $urandom_range(0, 19);
        if (r == 0) ticks = '0;
        else if (r == 1) ticks = '1;
        else if (r < 5) ticks = TickBits'($urandom_range(0, (1 << TickBits) - 1));
        else ticks = TickBits'($urandom_range(1, 8));
        queue_req(OP_INSERT, pick_tid(), ticks);
      end else if (r < 80) begin
        queue_req(OP_TICK, IdBits'($urandom_range(0, 255)),
                  TickBits'($urandom_range(0, 65535)));
      end else if (r < 96) begin
        queue_req(OP_REMOVE, pick_tid(), TickBits'($urandom_range(0, 65535)));
      end else begin
        queue_req(OP_CLEAR, IdBits'($urandom_range(0, 255)),
                  TickBits'($urandom_range(0, 65535)));
      end
    end
    total_n = req_fifo.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_n == total_n && awaited_words.size() == 0);
    repeat (40) @(posedge clk_i);
    if (mismatch_n == 0) begin
      $display("[delta_timer_queue] OK");
    end else begin
      $display("[delta_timer_queue] ERROR");
    end
    $finish;
  end

endmodule

@@ delta_timer_queue.f @@
sv/dtq_pkg.sv
sv/dtq_datapath.sv
sv/dtq_ctrl.sv
sv/delta_timer_queue.sv
bench/delta_timer_queue_test.sv
